>>> rtl/core/lfrc_pkg.sv
// package for the link frame receive checker: payload types, codes and frame check update
`default_nettype none

package lfrc_pkg;

  // status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_CHECK_FAIL = 4'd2;
  localparam logic [3:0] ST_NOT_ACKED  = 4'd3;
  localparam logic [3:0] ST_WRONG_ACK  = 4'd4;
  localparam logic [3:0] ST_CTRL_LEN   = 4'd5;
  localparam logic [3:0] ST_BAD_CTRL   = 4'd6;
  localparam logic [3:0] ST_UNEXP_CTRL = 4'd7;
  localparam logic [3:0] ST_BAD_LEN    = 4'd8;

  // frame layout
  localparam int unsigned CTRL_FRAME_BYTES = 5;
  localparam logic [7:0] FTYPE_MASK  = 8'h80;
  localparam logic [7:0] SEQCTR_MASK = 8'h60;
  localparam logic [7:0] FRNR_MASK   = 8'h0C;
  localparam logic [7:0] ACKNR_MASK  = 8'h03;
  localparam logic [7:0] NIB_MASK    = 8'h0F;
  localparam logic [7:0] BYTE_MASK   = 8'hFF;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last;
    logic       expect_control;
  } lfrc_in_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] payload_len;
    logic       send_ack;
    logic [1:0] ack_number;
    logic       duplicate_ack;
    logic [1:0] next_tx_number;
  } lfrc_out_t;

  // summary of a finished frame, valid on its last byte
  typedef struct packed {
    logic        too_short;
    logic        too_long;
    logic        check_ok;
    logic        is_ctrl_len;
    logic        len_match;
    logic        mode;
    logic [7:0]  ctrl;
    logic [15:0] length;
  } lfrc_frame_t;

  // one byte of the 16-bit frame check
  function automatic logic [15:0] check_update(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0]  a;
    logic [3:0]  lo;
    logic [7:0]  m;
    logic [3:0]  hi;
    logic [15:0] t;
    a  = (acc[7:0] ^ b) & BYTE_MASK;
    lo = a[3:0] & NIB_MASK[3:0];
    m  = {lo, 4'h0} ^ a;
    hi = m[7:4];
    t  = {7'h00, m, 1'b0} ^ {12'h000, hi};
    t  = {t[11:0], 4'h0} ^ {12'h000, lo};
    t  = {t[12:0], 3'b000};
    return t ^ {12'h000, hi} ^ {8'h00, acc[15:8]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lfrc_frame_track.sv
// per-frame tracking: byte count, header capture, trailer hold and running frame check
`default_nettype none

module lfrc_frame_track
  import lfrc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire lfrc_in_t    byte_in,
  output lfrc_frame_t      frame
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAXL = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_CTRL = CNT_W'(CTRL_FRAME_BYTES);
  localparam logic [16:0]      LEN_CTRL = 17'(CTRL_FRAME_BYTES);

  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       ctrl_r, ctrl_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [7:0]       hold0_r, hold0_nxt, hold1_r, hold1_nxt;
  logic             mode_r, mode_nxt;

  logic first, second, third;

  assign first  = (cnt_r == '0);
  assign second = (cnt_r == CNT_W'(1));
  assign third  = (cnt_r == CNT_W'(2));

  always_comb begin
    mode_nxt  = first ? byte_in.expect_control : mode_r;
    ctrl_nxt  = first ? byte_in.rx_byte : ctrl_r;
    len_nxt   = len_r;
    if (second) begin
      len_nxt = {byte_in.rx_byte, len_r[7:0]};
    end else if (third) begin
      len_nxt = {len_r[15:8], byte_in.rx_byte};
    end
    crc_nxt   = (!first && !second) ? check_update(crc_r, hold0_r) : crc_r;
    hold0_nxt = hold1_r;
    hold1_nxt = byte_in.rx_byte;
    cnt_nxt   = (cnt_r < CNT_SAT) ? cnt_r + CNT_W'(1) : cnt_r;
  end

  // frame summary on the current byte, taken as its last
  always_comb begin
    frame.too_short   = (cnt_nxt < CNT_CTRL);
    frame.too_long    = (cnt_nxt > CNT_MAXL);
    frame.check_ok    = (crc_nxt == {hold0_nxt, hold1_nxt});
    frame.is_ctrl_len = (cnt_nxt == CNT_CTRL);
    frame.len_match   = (({1'b0, len_nxt} + LEN_CTRL) == 17'(cnt_nxt));
    frame.mode        = mode_nxt;
    frame.ctrl        = ctrl_nxt;
    frame.length      = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && byte_in.last)) begin
      crc_r   <= '0;
      cnt_r   <= '0;
      ctrl_r  <= '0;
      len_r   <= '0;
      hold0_r <= '0;
      hold1_r <= '0;
      mode_r  <= 1'b0;
    end else if (step) begin
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      ctrl_r  <= ctrl_nxt;
      len_r   <= len_nxt;
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
      mode_r  <= mode_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lfrc_link_state.sv
// link sequencing state, end-of-frame decision and result register
`default_nettype none

module lfrc_link_state
  import lfrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire lfrc_frame_t frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output lfrc_out_t        out_data
);

  logic [1:0] tx_r, tx_nxt;
  logic [1:0] ack_last_r, ack_last_nxt;
  logic [1:0] rxn_r, rxn_nxt;
  logic       valid_r;
  lfrc_out_t  res_r, res_nxt;
  logic [1:0] ack;

  assign ack = frame.ctrl[1:0] & ACKNR_MASK[1:0];

  always_comb begin
    tx_nxt       = tx_r;
    ack_last_nxt = ack_last_r;
    rxn_nxt      = rxn_r;
    res_nxt      = '0;
    res_nxt.status = ST_OK;
    if (frame.too_short) begin
      res_nxt.status = ST_SHORT;
    end else if (frame.too_long) begin
      res_nxt.status = frame.mode ? ST_CTRL_LEN : ST_BAD_LEN;
    end else if (!frame.check_ok) begin
      res_nxt.status = ST_CHECK_FAIL;
    end else if ((frame.ctrl & SEQCTR_MASK) != 8'h00) begin
      res_nxt.status = ST_NOT_ACKED;
    end else begin
      if (tx_r == ack) begin
        tx_nxt       = tx_r + 2'd1;
        ack_last_nxt = ack;
      end else if (ack_last_r == ack) begin
        res_nxt.duplicate_ack = 1'b1;
      end else begin
        res_nxt.status = ST_WRONG_ACK;
      end
      if (res_nxt.status == ST_OK) begin
        if (frame.mode) begin
          if (!frame.is_ctrl_len) begin
            res_nxt.status = ST_CTRL_LEN;
          end else if ((frame.ctrl & FTYPE_MASK) == 8'h00 || frame.length != 16'h0000) begin
            res_nxt.status = ST_BAD_CTRL;
          end
        end else if ((frame.ctrl & FTYPE_MASK) != 8'h00) begin
          res_nxt.status = ST_UNEXP_CTRL;
        end else if (!frame.len_match) begin
          res_nxt.status = ST_BAD_LEN;
        end else begin
          rxn_nxt              = frame.ctrl[3:2] & FRNR_MASK[3:2];
          res_nxt.payload_len  = frame.length[7:0];
          res_nxt.send_ack     = 1'b1;
          res_nxt.ack_number   = rxn_nxt;
        end
      end
    end
    res_nxt.next_tx_number = tx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r       <= '0;
      ack_last_r <= '0;
      rxn_r      <= '0;
      valid_r    <= 1'b0;
    end else begin
      if (fire) begin
        tx_r       <= tx_nxt;
        ack_last_r <= ack_last_nxt;
        rxn_r      <= rxn_nxt;
        valid_r    <= 1'b1;
      end else if (out_ready) begin
        valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;

endmodule

`default_nettype wire

>>> rtl/core/link_frame_receive_checker.sv
// top level of the link frame receive checker
//
// usage:
//   in channel: one frame byte per transfer (in_data.rx_byte), with in_data.last on the
//   final byte and in_data.expect_control sampled on the first byte of each frame
//   out channel: one result transfer per frame, produced when the last byte is processed;
//   bytes that are not last produce nothing
//   path: a byte is held in the input register, and a result enters the result register
//   when the last byte of its frame leaves the input register
//   throughput: one byte per cycle unless a last byte waits; the byte-wide frame check
//   update and the end-of-frame decision are combinational between input and result registers
//   stall: while a result waits in the output register, further non-last bytes keep
//   flowing; a last byte waits in the input register until the result is taken, and
//   in_ready drops only then
//   reset: rst_n clears the frame state, the transmit, acknowledge and receive frame
//   numbers and both valid flags
//   MAX_FRAME_BYTES: longest accepted frame; the byte counter saturates one above it
`default_nettype none

module link_frame_receive_checker
  import lfrc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire lfrc_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output lfrc_out_t      out_data
);

  // input register
  logic        stg_valid_r;
  lfrc_in_t    stg_data_r;
  logic        advance;
  logic        fire;
  lfrc_frame_t frame;

  // a last byte needs room in the result register, other bytes always move on
  assign advance  = stg_valid_r && (!stg_data_r.last || !out_valid || out_ready);
  assign fire     = advance && stg_data_r.last;
  assign in_ready = !stg_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_data_r <= in_data;
    end
  end

  // per-frame counting, header capture and frame check
  lfrc_frame_track #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (stg_data_r),
    .frame   (frame)
  );

  // sequence numbers, decision and result register
  lfrc_link_state u_link (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .frame     (frame),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/link_frame_receive_checker_tb.sv
// self-checking testbench for the link frame receive checker: frame stimulus, predictor, checker
`timescale 1ns / 1ps

module link_frame_receive_checker_tb;
  import lfrc_pkg::*;

  localparam int MAX_LEN = 256;

  // one pending byte transfer; hold makes the sender wait until all results are in
  typedef struct {
    lfrc_in_t item;
    bit       hold;
  } pending_byte_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lfrc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lfrc_out_t out_data;

  pending_byte_t pend_q[$];
  lfrc_out_t     result_q[$];
  logic [7:0]    frame_buf[$];

  int fail_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic [7:0] stall_cyc = '0;
  int stall_mode = 0;
  lfrc_out_t want;

  // predictor state, mirrors the receive path of the block
  logic [15:0] chk_acc = '0;
  logic [8:0]  nbytes = '0;
  logic [7:0]  hdr_ctrl = '0;
  logic [15:0] len_word = '0;
  logic [7:0]  tail [2] = '{8'h00, 8'h00};
  logic        frame_mode = 1'b0;
  logic [1:0]  tx_seq = '0;
  logic [1:0]  acked_seq = '0;
  logic [1:0]  rx_seq = '0;

  // stimulus side view of the transmit number, only used to steer the acknowledge field
  logic [1:0]  gen_tx = '0;
  logic [1:0]  gen_last = '0;

  link_frame_receive_checker #(
    .MAX_FRAME_BYTES(MAX_LEN)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  // byte-wise update of the 16-bit frame check
  function automatic logic [15:0] frame_check(input logic [15:0] acc, input logic [7:0] b);
    logic [31:0] x;
    logic [31:0] lo;
    logic [31:0] mix;
    logic [31:0] hi;
    logic [31:0] r;
    x   = {24'd0, acc[7:0] ^ b};
    lo  = x & 32'h0000_000F;
    mix = ((lo << 4) ^ x) & 32'h0000_FFFF;
    hi  = mix >> 4;
    r   = (((((mix << 1) ^ hi) << 4) ^ lo) << 3) ^ hi ^ ({16'd0, acc} >> 8);
    return r[15:0];
  endfunction

  function automatic string fmt_result(input lfrc_out_t r);
    return $sformatf("status=%0d len=%0d send_ack=%0b ack_no=%0d dup=%0b next_tx=%0d",
                     r.status, r.payload_len, r.send_ack, r.ack_number, r.duplicate_ack,
                     r.next_tx_number);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // advance the predictor by one accepted byte; on a last byte queue the expected result
  function automatic void predict_byte(input lfrc_in_t it);
    lfrc_out_t r;
    logic [1:0] ack_no;
    r = '0;
    if (nbytes == 9'd0) begin
      frame_mode = it.expect_control;
      hdr_ctrl = it.rx_byte;
    end else if (nbytes == 9'd1) begin
      len_word[15:8] = it.rx_byte;
    end else if (nbytes == 9'd2) begin
      len_word[7:0] = it.rx_byte;
    end
    // the last two bytes are held back as the trailer
    if (nbytes >= 9'd2)
      chk_acc = frame_check(chk_acc, tail[0]);
    tail[0] = tail[1];
    tail[1] = it.rx_byte;
    if (nbytes < 9'(MAX_LEN + 1))
      nbytes = nbytes + 9'd1;
    if (!it.last)
      return;

    if (nbytes < CTRL_FRAME_BYTES) begin
      r.status = ST_SHORT;
    end else if (nbytes > MAX_LEN) begin
      r.status = frame_mode ? ST_CTRL_LEN : ST_BAD_LEN;
    end else if (chk_acc != {tail[0], tail[1]}) begin
      r.status = ST_CHECK_FAIL;
    end else if ((hdr_ctrl & SEQCTR_MASK) != 8'h00) begin
      r.status = ST_NOT_ACKED;
    end else begin
      ack_no = hdr_ctrl[1:0];
      if (tx_seq == ack_no) begin
        tx_seq = tx_seq + 2'd1;
        acked_seq = ack_no;
      end else if (acked_seq == ack_no) begin
        r.duplicate_ack = 1'b1;
      end else begin
        r.status = ST_WRONG_ACK;
      end
      // the acknowledge stays applied whatever the frame type checks say
      if (r.status == ST_OK) begin
        if (frame_mode) begin
          if (nbytes != CTRL_FRAME_BYTES)
            r.status = ST_CTRL_LEN;
          else if ((hdr_ctrl & FTYPE_MASK) == 8'h00 || len_word != 16'h0000)
            r.status = ST_BAD_CTRL;
        end else if ((hdr_ctrl & FTYPE_MASK) != 8'h00) begin
          r.status = ST_UNEXP_CTRL;
        end else if (32'(len_word) + CTRL_FRAME_BYTES != 32'(nbytes)) begin
          r.status = ST_BAD_LEN;
        end else begin
          rx_seq = hdr_ctrl[3:2];
          r.payload_len = len_word[7:0];
          r.send_ack = 1'b1;
          r.ack_number = rx_seq;
        end
      end
    end
    r.next_tx_number = tx_seq;
    result_q.push_back(r);

    // per-frame state clears after every last byte
    chk_acc = '0;
    nbytes = '0;
    hdr_ctrl = '0;
    len_word = '0;
    tail[0] = '0;
    tail[1] = '0;
    frame_mode = 1'b0;
  endfunction

  // turn frame_buf into byte transfers; expect_control only matters on the first byte
  task automatic emit_frame(input bit mode, input bit hold);
    pending_byte_t p;
    foreach (frame_buf[i]) begin
      p.item.rx_byte = frame_buf[i];
      p.item.last = (i == frame_buf.size() - 1);
      p.item.expect_control = (i == 0) ? mode : 1'($urandom_range(0, 1));
      p.hold = hold && (i == 0);
      pend_q.push_back(p);
    end
  endtask

  // header, payload and a big-endian frame check trailer, optionally corrupted
  task automatic add_frame(input logic [7:0] ctrl, input logic [15:0] len_fld, input int plen,
                           input bit mode, input bit corrupt, input bit hold);
    logic [15:0] acc;
    frame_buf = {};
    frame_buf.push_back(ctrl);
    frame_buf.push_back(len_fld[15:8]);
    frame_buf.push_back(len_fld[7:0]);
    for (int i = 0; i < plen; i++)
      frame_buf.push_back(8'($urandom_range(0, 255)));
    acc = '0;
    foreach (frame_buf[i])
      acc = frame_check(acc, frame_buf[i]);
    if (corrupt)
      acc = acc ^ 16'($urandom_range(1, 65535));
    frame_buf.push_back(acc[15:8]);
    frame_buf.push_back(acc[7:0]);
    emit_frame(mode, hold);
    // a frame that gets past the early checks with a matching acknowledge moves tx on
    if (!corrupt && ctrl[6:5] == 2'b00 && frame_buf.size() <= MAX_LEN &&
        ctrl[1:0] == gen_tx) begin
      gen_last = gen_tx;
      gen_tx = gen_tx + 2'd1;
    end
  endtask

  task automatic add_short_frame(input int nb, input bit mode, input bit hold);
    frame_buf = {};
    for (int i = 0; i < nb; i++)
      frame_buf.push_back(8'($urandom_range(0, 255)));
    emit_frame(mode, hold);
  endtask

  // mostly well-formed frames with random content, the rest broken on purpose
  task automatic add_random_frame(input bit hold);
    int kind;
    int plen;
    logic [7:0] ctrl;
    logic [15:0] len_fld;
    bit mode;
    bit corrupt;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0)
      plen = $urandom_range(41, 120);
    else if ($urandom_range(0, 3) == 0)
      plen = $urandom_range(7, 40);
    else
      plen = $urandom_range(0, 6);
    ctrl = {1'b0, 2'b00, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), gen_tx};
    len_fld = 16'(plen);
    mode = 1'b0;
    corrupt = 1'b0;
    if (kind < 40) begin
      // good data frame, nothing to change
    end else if (kind < 52) begin
      // good control frame
      ctrl[7] = 1'b1;
      len_fld = '0;
      plen = 0;
      mode = 1'b1;
    end else if (kind < 57) begin
      // repeated acknowledge
      ctrl[1:0] = gen_last;
    end else if (kind < 62) begin
      // acknowledge matching neither tx nor the last accepted one
      ctrl[1:0] = gen_tx + 2'd2;
    end else if (kind < 67) begin
      add_short_frame($urandom_range(1, 4), 1'($urandom_range(0, 1)), hold);
      return;
    end else if (kind < 73) begin
      corrupt = 1'b1;
      mode = 1'($urandom_range(0, 1));
      ctrl[7] = mode;
      if (mode) begin
        len_fld = '0;
        plen = 0;
      end
    end else if (kind < 78) begin
      ctrl[6:5] = 2'($urandom_range(1, 3));
    end else if (kind < 82) begin
      // control expected but the frame is longer than a control frame
      mode = 1'b1;
      ctrl[7] = 1'($urandom_range(0, 1));
      plen = $urandom_range(1, 8);
      len_fld = 16'($urandom_range(0, 65535));
    end else if (kind < 86) begin
      // control-sized frame with a wrong type bit or a nonzero length
      mode = 1'b1;
      plen = 0;
      if ($urandom_range(0, 1) == 0) begin
        len_fld = '0;
      end else begin
        ctrl[7] = 1'b1;
        len_fld = 16'($urandom_range(1, 65535));
      end
    end else if (kind < 90) begin
      // control frame while data is expected
      ctrl[7] = 1'b1;
    end else if (kind < 95) begin
      // length field that does not match, sometimes with the high byte set
      if ($urandom_range(0, 1) == 0)
        len_fld = 16'(plen + $urandom_range(1, 3));
      else
        len_fld = {8'($urandom_range(1, 255)), 8'(plen)};
    end else begin
      // noise: anything in the header, mostly a bad check
      ctrl = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0)
        len_fld = 16'($urandom_range(0, 65535));
      mode = 1'($urandom_range(0, 1));
      corrupt = ($urandom_range(0, 3) != 0);
    end
    add_frame(ctrl, len_fld, plen, mode, corrupt, hold);
  endtask

  // sender: bursts of random length with random gaps, fed from pend_q
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready)
        predict_byte(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0 && !(pend_q[0].hold && result_q.size() != 0)) begin
          in_valid <= 1'b1;
          in_data <= pend_q[0].item;
          pend_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer, stalls in phases with a randomly drawn ready pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_cyc <= '0;
      stall_mode <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          note_failure({"unexpected result: ", fmt_result(out_data)});
        end else begin
          want = result_q.pop_front();
          if (out_data.status !== want.status || out_data.payload_len !== want.payload_len ||
              out_data.send_ack !== want.send_ack || out_data.ack_number !== want.ack_number ||
              out_data.duplicate_ack !== want.duplicate_ack ||
              out_data.next_tx_number !== want.next_tx_number)
            note_failure({"mismatch: expected ", fmt_result(want), " got ",
                          fmt_result(out_data)});
        end
      end
      stall_cyc <= stall_cyc + 8'd1;
      if (stall_cyc[5:0] == 6'd63)
        stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (stall_cyc[1:0] == 2'd3);
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  initial begin
    int frame_no;
    int rand_items;
    int q_mark;

    // directed: two short lengths, good control and data frames, bad check, wide length
    frame_buf = {8'hFF};
    emit_frame(1'b1, 1'b0);
    frame_buf = {8'h00, 8'h00, 8'h00, 8'h00};
    emit_frame(1'b0, 1'b0);
    add_frame(FTYPE_MASK | 8'h10 | {6'd0, gen_tx}, 16'h0000, 0, 1'b1, 1'b0, 1'b0);
    add_frame(FRNR_MASK | {6'd0, gen_tx}, 16'h0000, 0, 1'b0, 1'b0, 1'b0);
    add_frame({6'd0, gen_tx}, 16'h0000, 0, 1'b0, 1'b1, 1'b0);
    add_frame({6'd0, gen_tx}, 16'h0100, 0, 1'b0, 1'b0, 1'b0);

    // random frames; one frame of the largest accepted length and one overlong frame in between
    frame_no = 0;
    rand_items = 0;
    while (rand_items < 730) begin
      q_mark = pend_q.size();
      add_random_frame(frame_no % 25 == 10);
      if (frame_no == 20)
        add_frame({2'b00, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), gen_tx},
                  16'(MAX_LEN - CTRL_FRAME_BYTES), MAX_LEN - CTRL_FRAME_BYTES, 1'b0, 1'b0,
                  1'b0);
      if (frame_no == 30)
        add_frame({2'b00, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), gen_tx},
                  16'($urandom_range(0, 65535)), MAX_LEN, 1'($urandom_range(0, 1)),
                  1'b0, 1'b0);
      rand_items = rand_items + pend_q.size() - q_mark;
      frame_no++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // all bytes transferred, then all results in, then a wait for strays
    while (pend_q.size() != 0 || in_valid)
      @(posedge clk);
    while (result_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
